>>> hw/rtl/ssct_pkg.sv
`timescale 1ns / 1ps

package ssct_pkg;

    // fixed field widths of the stream beats
    localparam int OP_W     = 3;
    localparam int IDX_W    = 10;
    localparam int VER_W    = 16;
    localparam int SLOT_W   = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    // packed beat widths, rounded up to whole bytes
    localparam int IN_BITS   = OP_W + IDX_W + VER_W + SLOT_W + DATA_W;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = STATUS_W + 1 + SLOT_W + DATA_W + IDX_W + VER_W + COUNT_W;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    // default sizes
    localparam int ENTITY_SLOTS_DEF = 1024;
    localparam int PACKED_SLOTS_DEF = 256;
    localparam int VERSION_BITS_DEF = 16;
    localparam int DATA_BITS_DEF    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ATTACH = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_INVALID   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4,
        ST_SLOT_OOR  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_OWN,
        S_EVAL,
        S_LAST,
        S_UNMAP
    } t_state;

    // result beat, status in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [VER_W-1:0]   owner_version;
        logic [IDX_W-1:0]   owner_index;
        logic [DATA_W-1:0]  data_out;
        logic [SLOT_W-1:0]  slot;
        logic               present;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

>>> hw/rtl/sparse_set_component_table.sv
`timescale 1ns / 1ps
// attach, lookup, read at slot and write data pass through the states map, own and eval; remove
// adds a second read of the last slot, then two map writes (states last and unmap)
// one item at a time: no new input beat is taken until the result of the last one is built;
// a finished result waits in the output register
// reset: synchronous, active low; afterwards all ENTITY_SLOTS map entries (1024 by default)
// are swept to invalid, during which no input beat is taken
module sparse_set_component_table #(
    parameter int ENTITY_SLOTS = ssct_pkg::ENTITY_SLOTS_DEF,
    parameter int PACKED_SLOTS = ssct_pkg::PACKED_SLOTS_DEF,
    parameter int VERSION_BITS = ssct_pkg::VERSION_BITS_DEF,
    parameter int DATA_BITS    = ssct_pkg::DATA_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // opcode, entity_index, entity_version, dense_slot, write_value, zero pad
    input  logic [ssct_pkg::IN_BYTES*8-1:0]  i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // status, present, slot, data_out, owner_index, owner_version, count, zero pad
    output logic [ssct_pkg::OUT_BYTES*8-1:0] o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready
);

    localparam int EW = $clog2(ENTITY_SLOTS);
    localparam int SW = PACKED_SLOTS > 1 ? $clog2(PACKED_SLOTS) : 1;
    localparam int MW = $clog2(PACKED_SLOTS + 1);
    localparam int VW = VERSION_BITS < ssct_pkg::VER_W ? VERSION_BITS : ssct_pkg::VER_W;
    localparam int DW = DATA_BITS < ssct_pkg::DATA_W ? DATA_BITS : ssct_pkg::DATA_W;
    localparam int OW = ssct_pkg::IDX_W + VW;
    localparam logic [MW-1:0] NO_SLOT = MW'(PACKED_SLOTS);

    // input field positions
    localparam int P_IDX  = ssct_pkg::OP_W;
    localparam int P_VER  = P_IDX + ssct_pkg::IDX_W;
    localparam int P_SLOT = P_VER + ssct_pkg::VER_W;
    localparam int P_DAT  = P_SLOT + ssct_pkg::SLOT_W;

    ssct_pkg::t_state  r_state, n_state;
    logic [EW-1:0]                 r_clr, n_clr;
    logic [ssct_pkg::OP_W-1:0]     r_op, n_op;
    logic [ssct_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [VW-1:0]                 r_ver, n_ver;
    logic [ssct_pkg::SLOT_W-1:0]   r_dslot, n_dslot;
    logic [DW-1:0]                 r_wval, n_wval;
    logic [SW-1:0]                 r_slot, n_slot;
    logic                          r_inrange, n_inrange;
    logic [MW-1:0]                 r_used, n_used;
    ssct_pkg::t_result             r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    // memory ports
    logic          map_we;
    logic [EW-1:0] map_waddr, map_raddr;
    logic [MW-1:0] map_wdata, map_q;
    logic          own_we;
    logic [SW-1:0] own_waddr, own_raddr;
    logic [OW-1:0] own_wdata, own_q;
    logic          dat_we;
    logic [DW-1:0] dat_wdata, dat_q;

    logic s_accept, out_free, load_out;
    logic [ssct_pkg::IDX_W-1:0] own_idx;
    logic [VW-1:0]              own_ver;
    logic idx_ok, have, invalid_id, full, moved_ok, remove_hit, eval_done;
    logic [SW-1:0] last_slot;
    logic [MW-1:0] used_dec;

    ssct_ram #(.WIDTH(MW), .DEPTH(ENTITY_SLOTS)) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(map_waddr),
        .i_wdata(map_wdata),
        .i_raddr(map_raddr),
        .o_rdata(map_q)
    );

    ssct_ram #(.WIDTH(OW), .DEPTH(PACKED_SLOTS)) u_owner (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_waddr(own_waddr),
        .i_wdata(own_wdata),
        .i_raddr(own_raddr),
        .o_rdata(own_q)
    );

    ssct_ram #(.WIDTH(DW), .DEPTH(PACKED_SLOTS)) u_data (
        .i_clk  (i_clk),
        .i_we   (dat_we),
        .i_waddr(own_waddr),
        .i_wdata(dat_wdata),
        .i_raddr(own_raddr),
        .o_rdata(dat_q)
    );

    assign o_s_tready = (r_state == ssct_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(ssct_pkg::OUT_BYTES*8 - ssct_pkg::OUT_BITS){1'b0}}, r_out};

    // presence and attach checks on the owner read at the mapped slot
    assign own_idx    = own_q[ssct_pkg::IDX_W-1:0];
    assign own_ver    = own_q[OW-1:ssct_pkg::IDX_W];
    assign idx_ok     = 32'(r_idx) < ENTITY_SLOTS;
    assign have       = idx_ok && r_inrange && (own_idx == r_idx) && (own_ver == r_ver);
    assign invalid_id = (&r_idx) && (VERSION_BITS <= ssct_pkg::VER_W) && (&r_ver);
    assign full       = (r_used == NO_SLOT) || !idx_ok;
    assign moved_ok   = 32'(own_idx) < ENTITY_SLOTS;
    assign used_dec   = r_used - MW'(1);
    assign last_slot  = SW'(used_dec);
    assign remove_hit = (r_op == ssct_pkg::OP_REMOVE) && have;
    assign eval_done  = !remove_hit && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssct_pkg::S_CLEAR: begin
                if (r_clr == EW'(ENTITY_SLOTS - 1)) n_state = ssct_pkg::S_IDLE;
            end
            ssct_pkg::S_IDLE: begin
                if (s_accept) n_state = ssct_pkg::S_MAP;
            end
            ssct_pkg::S_MAP:  n_state = ssct_pkg::S_OWN;
            ssct_pkg::S_OWN:  n_state = ssct_pkg::S_EVAL;
            ssct_pkg::S_EVAL: begin
                if (remove_hit) n_state = ssct_pkg::S_LAST;
                else if (out_free) n_state = ssct_pkg::S_IDLE;
            end
            ssct_pkg::S_LAST: n_state = ssct_pkg::S_UNMAP;
            ssct_pkg::S_UNMAP: begin
                if (out_free) n_state = ssct_pkg::S_IDLE;
            end
            default: n_state = ssct_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr     = r_clr;
        n_op      = r_op;
        n_idx     = r_idx;
        n_ver     = r_ver;
        n_dslot   = r_dslot;
        n_wval    = r_wval;
        n_slot    = r_slot;
        n_inrange = r_inrange;
        n_used    = r_used;
        n_out     = r_out;
        load_out  = 1'b0;
        map_we    = 1'b0;
        map_waddr = EW'(r_idx);
        map_wdata = NO_SLOT;
        map_raddr = EW'(r_idx);
        own_we    = 1'b0;
        dat_we    = 1'b0;
        own_waddr = r_slot;
        own_wdata = {r_ver, r_idx};
        dat_wdata = '0;
        own_raddr = r_slot;

        unique case (r_state)
            ssct_pkg::S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                n_clr     = r_clr + EW'(1);
            end
            ssct_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_op    = i_s_tdata[ssct_pkg::OP_W-1:0];
                    n_idx   = i_s_tdata[P_IDX +: ssct_pkg::IDX_W];
                    n_ver   = i_s_tdata[P_VER +: VW];
                    n_dslot = i_s_tdata[P_SLOT +: ssct_pkg::SLOT_W];
                    n_wval  = i_s_tdata[P_DAT +: DW];
                end
            end
            ssct_pkg::S_MAP: begin
                map_raddr = EW'(r_idx);
            end
            ssct_pkg::S_OWN: begin
                // map entry is back: pick the slot and fetch its owner and data
                if (r_op == ssct_pkg::OP_READ) begin
                    n_slot    = SW'(r_dslot);
                    n_inrange = 32'(r_dslot) < 32'(r_used);
                end else begin
                    n_slot    = SW'(map_q);
                    n_inrange = map_q < r_used;
                end
                own_raddr = n_slot;
            end
            ssct_pkg::S_EVAL: begin
                // keep the slot on the read port while the result waits; a remove hit reads the last slot
                own_raddr = remove_hit ? last_slot : r_slot;
                n_out.count         = ssct_pkg::COUNT_W'(r_used);
                n_out.status        = ssct_pkg::ST_OK;
                n_out.present       = 1'b0;
                n_out.slot          = '0;
                n_out.data_out      = '0;
                n_out.owner_index   = '0;
                n_out.owner_version = '0;
                if (eval_done) begin
                    load_out = 1'b1;
                    priority case (ssct_pkg::t_op'(r_op))
                        ssct_pkg::OP_ATTACH: begin
                            if (have) begin
                                n_out.status        = ssct_pkg::ST_PRESENT;
                                n_out.present       = 1'b1;
                                n_out.slot          = ssct_pkg::SLOT_W'(r_slot);
                                n_out.data_out      = ssct_pkg::DATA_W'(dat_q);
                                n_out.owner_index   = own_idx;
                                n_out.owner_version = ssct_pkg::VER_W'(own_ver);
                            end else if (invalid_id) begin
                                n_out.status = ssct_pkg::ST_INVALID;
                            end else if (full) begin
                                n_out.status = ssct_pkg::ST_FULL;
                            end else begin
                                // append at the next free slot with cleared data
                                map_we    = 1'b1;
                                map_wdata = r_used;
                                own_we    = 1'b1;
                                dat_we    = 1'b1;
                                own_waddr = SW'(r_used);
                                n_used    = r_used + MW'(1);
                                n_out.count         = ssct_pkg::COUNT_W'(n_used);
                                n_out.present       = 1'b1;
                                n_out.slot          = ssct_pkg::SLOT_W'(r_used);
                                n_out.owner_index   = r_idx;
                                n_out.owner_version = ssct_pkg::VER_W'(r_ver);
                            end
                        end
                        ssct_pkg::OP_REMOVE: begin
                            n_out.status = ssct_pkg::ST_ABSENT;
                        end
                        ssct_pkg::OP_LOOKUP: begin
                            if (have) begin
                                n_out.present       = 1'b1;
                                n_out.slot          = ssct_pkg::SLOT_W'(r_slot);
                                n_out.data_out      = ssct_pkg::DATA_W'(dat_q);
                                n_out.owner_index   = own_idx;
                                n_out.owner_version = ssct_pkg::VER_W'(own_ver);
                            end else begin
                                n_out.status = ssct_pkg::ST_ABSENT;
                            end
                        end
                        ssct_pkg::OP_READ: begin
                            if (r_inrange) begin
                                n_out.present       = 1'b1;
                                n_out.slot          = ssct_pkg::SLOT_W'(r_slot);
                                n_out.data_out      = ssct_pkg::DATA_W'(dat_q);
                                n_out.owner_index   = own_idx;
                                n_out.owner_version = ssct_pkg::VER_W'(own_ver);
                            end else begin
                                n_out.status = ssct_pkg::ST_SLOT_OOR;
                            end
                        end
                        ssct_pkg::OP_WRITE: begin
                            if (have) begin
                                dat_we    = 1'b1;
                                dat_wdata = r_wval;
                                n_out.present       = 1'b1;
                                n_out.slot          = ssct_pkg::SLOT_W'(r_slot);
                                n_out.data_out      = ssct_pkg::DATA_W'(r_wval);
                                n_out.owner_index   = own_idx;
                                n_out.owner_version = ssct_pkg::VER_W'(own_ver);
                            end else begin
                                n_out.status = ssct_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            n_out.status = ssct_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ssct_pkg::S_LAST: begin
                // last slot's owner and data move into the freed slot
                own_we    = 1'b1;
                dat_we    = 1'b1;
                own_wdata = own_q;
                dat_wdata = dat_q;
                map_we    = moved_ok;
                map_waddr = EW'(own_idx);
                map_wdata = MW'(r_slot);
            end
            ssct_pkg::S_UNMAP: begin
                if (out_free) begin
                    map_we    = 1'b1;
                    map_waddr = EW'(r_idx);
                    map_wdata = NO_SLOT;
                    n_used    = used_dec;
                    load_out  = 1'b1;
                    n_out.count         = ssct_pkg::COUNT_W'(used_dec);
                    n_out.status        = ssct_pkg::ST_OK;
                    n_out.present       = 1'b0;
                    n_out.slot          = ssct_pkg::SLOT_W'(r_slot);
                    n_out.data_out      = '0;
                    n_out.owner_index   = '0;
                    n_out.owner_version = '0;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // output beat holds until taken
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssct_pkg::S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_ver     <= n_ver;
        r_dslot   <= n_dslot;
        r_wval    <= n_wval;
        r_slot    <= n_slot;
        r_inrange <= n_inrange;
        r_out     <= load_out ? n_out : r_out;
    end

    // slot count stays within the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= PACKED_SLOTS)
        else $error("slot count beyond table size");

    // slot count moves by at most one per item
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_used != $past(r_used))) |->
        ((r_used == $past(r_used) + MW'(1)) || (r_used == $past(r_used) - MW'(1))))
        else $error("slot count jumped");

    // an accepted beat closes the input until its result is built
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("second beat taken while busy");

    // a present result carries an ok or already-present status
    a_present_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.present) |->
        ((r_out.status == ssct_pkg::ST_OK) || (r_out.status == ssct_pkg::ST_PRESENT)))
        else $error("present flag with failing status");

    // the result count matches the table count when loaded
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(load_out)) |->
        (r_out.count == ssct_pkg::COUNT_W'(r_used)))
        else $error("reported count differs from table");

endmodule

>>> hw/rtl/ssct_ram.sv
`timescale 1ns / 1ps

module ssct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
